// File: src/hnft_pkg.sv
package hnft_pkg;

  localparam int unsigned FrameLenW = 10;
  localparam int unsigned FlagCntW  = 8;
  localparam int unsigned ByteW     = 8;

  localparam logic [FrameLenW-1:0] MaxFrameBytes = 10'd1023;
  localparam logic [ByteW-1:0]     FlagByte      = 8'h7E;
  localparam logic [2:0]           StuffLimit    = 3'd5;

  localparam logic [FlagCntW-1:0]  PreambleReset = 8'd32;
  localparam logic [FlagCntW-1:0]  TrailReset    = 8'd3;

  // configuration register indexes
  localparam logic CfgPreamble = 1'b0;
  localparam logic CfgTrail    = 1'b1;

  // operation codes
  localparam logic OpStart = 1'b0;
  localparam logic OpTick  = 1'b1;

  // frame phases
  localparam logic [1:0] PhIdle     = 2'd0;
  localparam logic [1:0] PhPreamble = 2'd1;
  localparam logic [1:0] PhData     = 2'd2;
  localparam logic [1:0] PhTrail    = 2'd3;

  typedef struct packed {
    logic                 operation;
    logic [FrameLenW-1:0] frame_length;
    logic [ByteW-1:0]     next_byte;
  } item_t;

  typedef struct packed {
    logic tone_space;
    logic byte_taken;
    logic busy_res;
    logic done_res;
  } result_t;

  typedef struct packed {
    logic                we;
    logic                index;
    logic [FlagCntW-1:0] data;
  } cfg_t;

endpackage

// File: src/hnft_in_reg.sv
module hnft_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  hnft_pkg::item_t item_i,
  output logic           valid_o,
  output hnft_pkg::item_t item_o
);
  import hnft_pkg::*;

  logic  valid_q;
  item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/hnft_core.sv
module hnft_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hnft_pkg::cfg_t     cfg_i,
  input  logic               adv_i,
  input  logic               valid_i,
  input  hnft_pkg::item_t    item_i,
  output logic               valid_o,
  output hnft_pkg::result_t  result_o
);
  import hnft_pkg::*;

  logic [FlagCntW-1:0]  preamble_cnt_q, trail_cnt_q;
  logic [1:0]           phase_q, phase_d;
  logic [ByteW-1:0]     shift_q, shift_d;
  logic [2:0]           bitpos_q, bitpos_d;
  logic [2:0]           ones_q, ones_d;
  logic [FlagCntW-1:0]  flags_q, flags_d;
  logic [FrameLenW-1:0] bytes_q, bytes_d;
  logic                 tone_q, tone_d;
  logic                 fin_q, fin_d;
  logic                 taken;
  logic                 cur_bit;
  logic                 load_next;
  logic [FrameLenW-1:0] len_sat;
  logic                 step;

  logic                 out_valid_q;
  result_t              result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_cnt_q <= PreambleReset;
      trail_cnt_q    <= TrailReset;
    end else if (cfg_i.we) begin
      if (cfg_i.index == CfgPreamble) begin
        preamble_cnt_q <= cfg_i.data;
      end else begin
        trail_cnt_q <= cfg_i.data;
      end
    end
  end

  assign step    = adv_i && valid_i;
  assign cur_bit = shift_q[bitpos_q];
  assign len_sat = (item_i.frame_length > MaxFrameBytes) ? MaxFrameBytes
                                                         : item_i.frame_length;

  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    bitpos_d  = bitpos_q;
    ones_d    = ones_q;
    flags_d   = flags_q;
    bytes_d   = bytes_q;
    tone_d    = tone_q;
    fin_d     = fin_q;
    taken     = 1'b0;
    load_next = 1'b0;
    if (item_i.operation == OpStart) begin
      phase_d  = PhPreamble;
      shift_d  = FlagByte;
      bitpos_d = 3'd0;
      ones_d   = 3'd0;
      flags_d  = preamble_cnt_q;
      bytes_d  = len_sat;
      tone_d   = 1'b0;
      fin_d    = 1'b0;
    end else if (phase_q != PhIdle) begin
      if (ones_q >= StuffLimit) begin
        // stuffed zero, bit position holds
        tone_d = ~tone_q;
        ones_d = 3'd0;
      end else begin
        if (!cur_bit) begin
          tone_d = ~tone_q;
          ones_d = 3'd0;
        end else if (phase_q == PhData) begin
          ones_d = ones_q + 3'd1;
        end else begin
          ones_d = 3'd0;
        end
        bitpos_d = bitpos_q + 3'd1;
        if (bitpos_q == 3'd7) begin
          case (phase_q)
            PhPreamble: begin
              if (flags_q > 8'd1) begin
                flags_d = flags_q - 8'd1;
                shift_d = FlagByte;
              end else begin
                flags_d   = '0;
                load_next = 1'b1;
              end
            end
            PhData: begin
              load_next = 1'b1;
            end
            PhTrail: begin
              if (flags_q > 8'd1) begin
                flags_d = flags_q - 8'd1;
                shift_d = FlagByte;
              end else begin
                flags_d = '0;
                phase_d = PhIdle;
                fin_d   = 1'b1;
              end
            end
            default: begin
              phase_d = PhIdle;
            end
          endcase
        end
      end
      if (load_next) begin
        if (bytes_q != '0) begin
          shift_d = item_i.next_byte;
          bytes_d = bytes_q - 10'd1;
          phase_d = PhData;
          taken   = 1'b1;
        end else begin
          phase_d = PhTrail;
          shift_d = FlagByte;
          flags_d = trail_cnt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      shift_q  <= FlagByte;
      bitpos_q <= 3'd0;
      ones_q   <= 3'd0;
      flags_q  <= '0;
      bytes_q  <= '0;
      tone_q   <= 1'b0;
      fin_q    <= 1'b0;
    end else if (step) begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      bitpos_q <= bitpos_d;
      ones_q   <= ones_d;
      flags_q  <= flags_d;
      bytes_q  <= bytes_d;
      tone_q   <= tone_d;
      fin_q    <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q.tone_space <= tone_d;
      result_q.byte_taken <= taken;
      result_q.busy_res   <= (phase_d != PhIdle);
      result_q.done_res   <= fin_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = result_q;

endmodule

// File: src/hdlc_nrzi_frame_transmitter.sv
// HDLC frame transmitter with bit stuffing and NRZI line coding.
// Input channel (in_valid_i / in_stall_o) carries one item per handshake:
// operation_i selects start of frame (with frame_length_i) or one bit-time
// tick; next_byte_i is the data byte offered with a tick and is consumed
// when the matching result reports byte_taken_o.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// item: tone_space_o, byte_taken_o, busy_res_o, done_res_o.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 = preamble flag count, 1 = trail flag count) at the clock edge.
// Pipeline: an accepted item is held in the input register, its result is
// computed from the frame state and registered in the result register,
// which drives out_valid_o.
// Throughput: one item per cycle unless the receiver stalls; the input
// register, the frame state and the result register advance in one step.
// When the receiver stalls with a result pending, the whole pipe holds and
// in_stall_o is raised in the same cycle; the result stays stable.
// Reset (rst_ni low, asynchronous) empties both registers, sets the phase to
// idle with mark tone, and loads flag counts of 32 and 3.
module hdlc_nrzi_frame_transmitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [9:0] frame_length_i,
  input  logic [7:0] next_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       tone_space_o,
  output logic       byte_taken_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import hnft_pkg::*;

  logic    adv;
  item_t   in_item, s1_item;
  logic    s1_valid;
  cfg_t    cfg;
  result_t result;

  // pipe moves unless a result is waiting and the receiver stalls
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign in_item.operation    = operation_i;
  assign in_item.frame_length = frame_length_i;
  assign in_item.next_byte    = next_byte_i;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  hnft_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  hnft_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .adv_i    (adv),
    .valid_i  (s1_valid),
    .item_i   (s1_item),
    .valid_o  (out_valid_o),
    .result_o (result)
  );

  assign tone_space_o = result.tone_space;
  assign byte_taken_o = result.byte_taken;
  assign busy_res_o   = result.busy_res;
  assign done_res_o   = result.done_res;

endmodule

// File: src/hnft_checker.sv
module hnft_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic tone_space_o,
  input logic byte_taken_o,
  input logic busy_res_o,
  input logic done_res_o
);

  // a taken byte always leaves the frame running
  a_taken_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_taken_o |-> busy_res_o && !done_res_o)
    else $error("byte taken outside a running frame");

  // finished and busy exclude each other
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(busy_res_o && done_res_o))
    else $error("done and busy both set");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tone_space_o) &&
      $stable(byte_taken_o) && $stable(busy_res_o) && $stable(done_res_o))
    else $error("stalled result changed");

endmodule

bind hdlc_nrzi_frame_transmitter hnft_checker u_hnft_checker (.*);
